// File: rtl/mdec_pkg.sv
// ----------------------------------------------------------------------------
// mdec_pkg
// Types, kind codes and decode helpers shared by the MOV decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package mdec_pkg;

	typedef enum logic [2:0] {
		KIND_REGMEM  = 3'd0,
		KIND_IMM_RM  = 3'd1,
		KIND_IMM_REG = 3'd2,
		KIND_ACC     = 3'd3,
		KIND_UNSUP   = 3'd4,
		KIND_TRUNC   = 3'd5,
		KIND_SKIP    = 3'd6
	} kind_t;

	localparam logic [3:0] OP_GRP_REGMEM = 4'b1000;
	localparam logic [3:0] OP_GRP_IMM_RM = 4'b1100;
	localparam logic [3:0] OP_GRP_IMM_REG = 4'b1011;
	localparam logic [5:0] OP_ACC = 6'b101000;
	localparam logic [2:0] RM_DIRECT = 3'b110;
	localparam logic [2:0] OP_IMM_RM_SUB = 3'b011;
	localparam logic [1:0] OP_REGMEM_SUB = 2'b10;
	localparam logic [1:0] MOD_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_DISP8 = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       stream_end;
	} code_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        to_register;
		logic        wide;
		logic [1:0]  mode;
		logic [2:0]  reg_field;
		logic [2:0]  rm_field;
		logic        direct_address;
		logic [15:0] displacement;
		logic [15:0] immediate;
	} result_item_t;

	// raw instruction record handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
	} instr_rec_t;

	function automatic kind_t classify(input logic [7:0] op);
		kind_t k;
		k = KIND_SKIP;
		if (op[7:4] == OP_GRP_REGMEM) begin
			k = (op[3:2] == OP_REGMEM_SUB) ? KIND_REGMEM : KIND_UNSUP;
		end else if (op[7:4] == OP_GRP_IMM_RM) begin
			k = (op[3:1] == OP_IMM_RM_SUB) ? KIND_IMM_RM : KIND_UNSUP;
		end else if (op[7:4] == OP_GRP_IMM_REG) begin
			k = KIND_IMM_REG;
		end else if (op[7:2] == OP_ACC) begin
			k = KIND_ACC;
		end
		return k;
	endfunction

	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		logic [1:0] n;
		case (modrm[7:6])
			MOD_NO_DISP: n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			MOD_DISP8:   n = 2'd1;
			MOD_DISP16:  n = 2'd2;
			default:     n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mdec_code_if.sv
// ----------------------------------------------------------------------------
// mdec_code_if
// Byte channel into the decoder: valid/ready with one code byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdec_code_if;
	import mdec_pkg::*;

	logic       valid;
	logic       ready;
	code_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mdec_result_if.sv
// ----------------------------------------------------------------------------
// mdec_result_if
// Result channel out of the decoder: valid/ready with one decoded MOV.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdec_result_if;
	import mdec_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mdec_front.sv
// ----------------------------------------------------------------------------
// mdec_front
// Byte-level phase tracker: classifies opcodes, captures ModR/M, displacement
// and immediate bytes, and pushes one raw record per finished instruction, unsupported opcode or truncated stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mdec_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	mdec_code_if.sink                   code,
	input  wire logic                   queue_full,
	output logic                        push,
	output mdec_pkg::instr_rec_t        push_rec
);
	import mdec_pkg::*;

	logic [2:0]  rem_q;
	logic [7:0]  op_q;
	logic [7:0]  modrm_q;
	logic [2:0]  pos_q;
	logic [15:0] disp_q;
	logic [15:0] imm_q;

	logic [2:0]  rem_n;
	logic [7:0]  op_n;
	logic [7:0]  modrm_n;
	logic [2:0]  pos_n;
	logic [15:0] disp_n;
	logic [15:0] imm_n;

	logic        accept;
	logic        emit;
	instr_rec_t  rec;

	assign code.ready = !queue_full;
	assign accept = code.valid && code.ready;

	always_comb begin
		kind_t      k;
		logic       has_modrm;
		logic [1:0] dl;
		logic [1:0] imm_len;
		logic [2:0] idx;
		logic [7:0] b;
		logic       last;

		b = code.data.code_byte;
		last = code.data.stream_end;
		rem_n = rem_q;
		op_n = op_q;
		modrm_n = modrm_q;
		pos_n = pos_q;
		disp_n = disp_q;
		imm_n = imm_q;
		emit = 1'b0;
		rec = '0;
		k = classify(op_q);
		has_modrm = (k == KIND_REGMEM) || (k == KIND_IMM_RM);
		dl = 2'd0;
		imm_len = 2'd0;
		idx = 3'd0;

		if (rem_q == 3'd0) begin
			k = classify(b);
			case (k)
				KIND_SKIP: begin
				end
				KIND_UNSUP: begin
					emit = 1'b1;
					rec.kind = KIND_UNSUP;
				end
				default: begin
					op_n = b;
					modrm_n = '0;
					disp_n = '0;
					imm_n = '0;
					pos_n = 3'd1;
					case (k)
						KIND_REGMEM, KIND_IMM_RM: rem_n = 3'd1;
						KIND_IMM_REG:             rem_n = b[3] ? 3'd2 : 3'd1;
						default:                  rem_n = 3'd2;
					endcase
					if (last) begin
						emit = 1'b1;
						rec.kind = KIND_TRUNC;
					end
				end
			endcase
		end else begin
			if (has_modrm && pos_q == 3'd1) begin
				imm_len = (k == KIND_IMM_RM) ? (op_q[0] ? 2'd2 : 2'd1) : 2'd0;
				modrm_n = b;
				rem_n = 3'(disp_len(b)) + 3'(imm_len);
			end else begin
				dl = has_modrm ? disp_len(modrm_q) : ((k == KIND_ACC) ? 2'd2 : 2'd0);
				idx = pos_q - (has_modrm ? 3'd2 : 3'd1);
				if (idx < 3'(dl)) begin
					if (idx == 3'd0) begin
						disp_n[7:0] = b;
					end else begin
						disp_n[15:8] = b;
					end
				end else if (idx == 3'(dl)) begin
					imm_n[7:0] = b;
				end else begin
					imm_n[15:8] = b;
				end
				rem_n = rem_q - 3'd1;
			end
			pos_n = pos_q + 3'd1;
			if (rem_n == 3'd0) begin
				emit = 1'b1;
				rec.kind = k;
				rec.opcode = op_q;
				rec.modrm = modrm_n;
				rec.disp = disp_n;
				rec.imm = imm_n;
			end else if (last) begin
				emit = 1'b1;
				rec.kind = KIND_TRUNC;
			end
		end

		// any emitted record returns the decoder to its opcode phase
		if (emit) begin
			rem_n = '0;
			op_n = '0;
			modrm_n = '0;
			pos_n = '0;
			disp_n = '0;
			imm_n = '0;
		end
	end

	assign push = accept && emit;
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			op_q <= '0;
			modrm_q <= '0;
			pos_q <= '0;
			disp_q <= '0;
			imm_q <= '0;
		end else if (accept) begin
			rem_q <= rem_n;
			op_q <= op_n;
			modrm_q <= modrm_n;
			pos_q <= pos_n;
			disp_q <= disp_n;
			imm_q <= imm_n;
		end
	end

	// stream end always leaves the decoder waiting for an opcode
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && code.data.stream_end |=> rem_q == 3'd0)
		else $error("stream end did not clear decode phase");

	// no instruction needs more than four further bytes
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd4)
		else $error("bytes remaining out of range");

	// a truncated record only comes from a byte marked as stream end
	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_rec.kind == KIND_TRUNC |-> code.data.stream_end)
		else $error("truncated record without stream end");

endmodule

`default_nettype wire

// File: rtl/mdec_queue.sv
// ----------------------------------------------------------------------------
// mdec_queue
// Small FIFO of raw instruction records between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mdec_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire mdec_pkg::instr_rec_t   push_rec,
	input  wire logic                   pop,
	output logic                        full,
	output logic                        empty,
	output mdec_pkg::instr_rec_t        head
);
	import mdec_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	instr_rec_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("record pushed into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

	// pointers agree whenever the queue is empty
	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree while empty");

endmodule

`default_nettype wire

// File: rtl/mdec_back.sv
// ----------------------------------------------------------------------------
// mdec_back
// Turns raw records into decoded result fields and holds them in the output
// register until the sink takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mdec_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   empty,
	input  wire mdec_pkg::instr_rec_t   head,
	output logic                        pop,
	mdec_result_if.source               result
);
	import mdec_pkg::*;

	logic         valid_q;
	result_item_t out_q;
	result_item_t fmt;

	always_comb begin
		logic [15:0] d;
		fmt = '0;
		fmt.kind = head.kind;
		d = head.disp;
		case (head.kind)
			KIND_REGMEM, KIND_IMM_RM: begin
				if (disp_len(head.modrm) == 2'd1) begin
					d = {{8{head.disp[7]}}, head.disp[7:0]};
				end
				fmt.to_register = (head.kind == KIND_REGMEM) ? head.opcode[1] : 1'b0;
				fmt.wide = head.opcode[0];
				fmt.mode = head.modrm[7:6];
				fmt.reg_field = (head.kind == KIND_REGMEM) ? head.modrm[5:3] : 3'd0;
				fmt.rm_field = head.modrm[2:0];
				fmt.direct_address = (head.modrm[7:6] == MOD_NO_DISP) &&
					(head.modrm[2:0] == RM_DIRECT);
				fmt.displacement = d;
				fmt.immediate = (head.kind == KIND_IMM_RM) ? head.imm : 16'd0;
			end
			KIND_IMM_REG: begin
				fmt.wide = head.opcode[3];
				fmt.reg_field = head.opcode[2:0];
				fmt.immediate = head.imm;
			end
			KIND_ACC: begin
				fmt.to_register = head.opcode[1];
				fmt.wide = head.opcode[0];
				fmt.displacement = head.disp;
			end
			default: begin
			end
		endcase
	end

	// refill the output register when it is free or being taken
	assign pop = !empty && (!valid_q || result.ready);
	assign result.valid = valid_q;
	assign result.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= fmt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/x86_16bit_mov_decoder.sv
// a finished instruction's record is written into the record queue, then into the back's output register
// throughput: one code byte per cycle while the record queue is not full, at most one result per byte
// code.ready drops only while the record queue between front and back is full
// reset clears the decode phase and all held fields, the queue and the output valid
// ----------------------------------------------------------------------------
// x86_16bit_mov_decoder
// 8086 MOV decoder: front tracks the byte stream, back formats decoded fields.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_16bit_mov_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mdec_code_if.sink     code,
	mdec_result_if.source result
);
	import mdec_pkg::*;

	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	instr_rec_t push_rec;
	instr_rec_t head;

	mdec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code       (code),
		.queue_full (full),
		.push       (push),
		.push_rec   (push_rec)
	);

	mdec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	mdec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire
